// File: rtl/bqe_pkg.sv
// Shared types and constants for the biquad band-pass energy block.
package bqe_pkg;

  localparam int COEF_BITS     = 18;
  localparam int FRAC_BITS     = 15;
  localparam int NUM_COEF      = 5;
  localparam int CFG_ADDR_BITS = 3;

  typedef logic [CFG_ADDR_BITS-1:0] reg_idx_t;

  localparam reg_idx_t REG_B0 = 3'd0;
  localparam reg_idx_t REG_B1 = 3'd1;
  localparam reg_idx_t REG_B2 = 3'd2;
  localparam reg_idx_t REG_A1 = 3'd3;
  localparam reg_idx_t REG_A2 = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_TAIL,
    ST_ROUND,
    ST_SQUARE,
    ST_ENERGY
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic mul_neg;
    logic acc_clr;
    logic acc_add;
  } mac_ctl_t;

  typedef struct packed {
    mac_ctl_t mac;
    reg_idx_t term;
    logic     sq_sel;
    logic     y_load;
    logic     out_load;
  } seq_ctl_t;

endpackage

// File: rtl/bqe_mac.sv
// Shared signed multiplier with registered product and accumulator.
module bqe_mac #(
  parameter int A_W   = 18,
  parameter int B_W   = 16,
  parameter int ACC_W = 37
) (
  input  logic                     clk,
  input  bqe_pkg::mac_ctl_t        ctl,
  input  logic signed [A_W-1:0]    op_a,
  input  logic signed [B_W-1:0]    op_b,
  output logic signed [A_W+B_W-1:0] prod_r,
  output logic signed [ACC_W-1:0]  acc_r
);

  logic                    neg_r;
  logic signed [ACC_W-1:0] p_ext;

  assign p_ext = ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= op_a * op_b;
      neg_r  <= ctl.mul_neg;
    end
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (ctl.acc_add) begin
      acc_r <= neg_r ? (acc_r - p_ext) : (acc_r + p_ext);
    end
  end

endmodule

// File: rtl/bqe_seq.sv
// Sequencer stepping one sample through the shared multiply-accumulate unit.
module bqe_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_free,
  output logic              in_ready,
  output bqe_pkg::seq_ctl_t ctl
);

  bqe_pkg::state_t   state_r, state_nxt;
  bqe_pkg::reg_idx_t term_r, term_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bqe_pkg::ST_IDLE;
      term_r  <= bqe_pkg::REG_B0;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    unique case (state_r)
      bqe_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = bqe_pkg::ST_MAC;
          term_nxt  = bqe_pkg::REG_B0;
        end
      end
      bqe_pkg::ST_MAC: begin
        term_nxt = term_r + 1'b1;
        if (term_r == bqe_pkg::REG_A2) begin
          state_nxt = bqe_pkg::ST_TAIL;
        end
      end
      bqe_pkg::ST_TAIL:   state_nxt = bqe_pkg::ST_ROUND;
      bqe_pkg::ST_ROUND:  state_nxt = bqe_pkg::ST_SQUARE;
      bqe_pkg::ST_SQUARE: state_nxt = bqe_pkg::ST_ENERGY;
      bqe_pkg::ST_ENERGY: begin
        if (out_free) begin
          state_nxt = bqe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bqe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctl      = '0;
    ctl.term = term_r;
    unique case (state_r)
      bqe_pkg::ST_IDLE: begin
        in_ready        = 1'b1;
        // accumulator held clear while waiting for a beat
        ctl.mac.acc_clr = 1'b1;
      end
      bqe_pkg::ST_MAC: begin
        ctl.mac.mul_en  = 1'b1;
        // feedback terms are subtracted
        ctl.mac.mul_neg = (term_r == bqe_pkg::REG_A1) || (term_r == bqe_pkg::REG_A2);
        ctl.mac.acc_add = (term_r != bqe_pkg::REG_B0);
      end
      bqe_pkg::ST_TAIL:   ctl.mac.acc_add = 1'b1;
      bqe_pkg::ST_ROUND:  ctl.y_load = 1'b1;
      bqe_pkg::ST_SQUARE: begin
        ctl.mac.mul_en = 1'b1;
        ctl.sq_sel     = 1'b1;
      end
      bqe_pkg::ST_ENERGY: ctl.out_load = out_free;
      default: ;
    endcase
  end

endmodule

// File: rtl/biquad_bandpass_energy.sv
// Direct-form-I biquad filter with saturating energy accumulator, top level.
// Each sample passes through these steps from one accept to the earliest next accept:
// five multiply steps, one step to add the last product, one to round and clamp,
// one to square the output, one to fold it into the energy sum, and one idle
// step with in_tready high. One 18x16 multiplier is shared by the five
// coefficient products and the square of the output, each product registered
// before it is accumulated.
// A beat with in_tuser set clears the filter history, the energy sum and the
// saturation flag before the sample is filtered. The result waits in an output
// register, so the next sample is taken while a result is still unread; the
// sequencer only holds in its last step when that register is still full.
// Coefficients are signed Q3.15 and may be written whenever no sample is in
// flight; writes to indexes past the five coefficients are dropped.
module biquad_bandpass_energy #(
  parameter int SAMPLE_BITS = 16,
  parameter int ENERGY_BITS = 48
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,  // sample_in
  input  logic                                 in_tuser,  // start_record

  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // filtered_sample, energy_total
  output logic [((SAMPLE_BITS+ENERGY_BITS+7)/8)*8-1:0] out_tdata,
  output logic                                 out_tuser, // energy_saturated

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bqe_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  logic [bqe_pkg::COEF_BITS-1:0]        cfg_data
);

  localparam int OUT_TW = ((SAMPLE_BITS + ENERGY_BITS + 7) / 8) * 8;
  localparam int MA_W   = (bqe_pkg::COEF_BITS > SAMPLE_BITS) ? bqe_pkg::COEF_BITS
                                                             : SAMPLE_BITS;
  localparam int P_W    = MA_W + SAMPLE_BITS;
  localparam int ACC_W  = P_W + 3;
  localparam int SH_W   = ACC_W - bqe_pkg::FRAC_BITS;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int SUM_W  = ((ENERGY_BITS > SQ_W) ? ENERGY_BITS : SQ_W) + 1;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (bqe_pkg::FRAC_BITS - 1);
  localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [ENERGY_BITS-1:0] E_MAX = '1;

  bqe_pkg::seq_ctl_t ctl;
  logic              in_fire;
  logic              out_free;

  logic signed [bqe_pkg::COEF_BITS-1:0] coef_r [bqe_pkg::NUM_COEF];
  logic signed [SAMPLE_BITS-1:0] x_r, x1_r, x2_r, y1_r, y2_r, y_r;
  logic [ENERGY_BITS-1:0]        energy_r, energy_nxt;
  logic                          esat_r, esat_nxt;
  logic                          out_valid_r;
  logic [OUT_TW-1:0]             out_data_r;
  logic                          out_user_r;

  logic signed [MA_W-1:0]        op_a;
  logic signed [SAMPLE_BITS-1:0] op_b;
  logic signed [P_W-1:0]         prod;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       rnd;
  logic signed [SH_W-1:0]        sh;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic [SUM_W-1:0]              sum;

  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  bqe_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .in_ready (in_tready),
    .ctl      (ctl)
  );

  bqe_mac #(
    .A_W   (MA_W),
    .B_W   (SAMPLE_BITS),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk    (clk),
    .ctl    (ctl.mac),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod),
    .acc_r  (acc)
  );

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (ctl.sq_sel) begin
      op_a = MA_W'(y_r);
      op_b = y_r;
    end else begin
      unique case (ctl.term)
        bqe_pkg::REG_B0: begin op_a = MA_W'(coef_r[bqe_pkg::REG_B0]); op_b = x_r;  end
        bqe_pkg::REG_B1: begin op_a = MA_W'(coef_r[bqe_pkg::REG_B1]); op_b = x1_r; end
        bqe_pkg::REG_B2: begin op_a = MA_W'(coef_r[bqe_pkg::REG_B2]); op_b = x2_r; end
        bqe_pkg::REG_A1: begin op_a = MA_W'(coef_r[bqe_pkg::REG_A1]); op_b = y1_r; end
        bqe_pkg::REG_A2: begin op_a = MA_W'(coef_r[bqe_pkg::REG_A2]); op_b = y2_r; end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end
  end

  // round half up by 2^-15, then clamp to the sample range
  always_comb begin
    rnd = acc + HALF;
    sh  = rnd[ACC_W-1:bqe_pkg::FRAC_BITS];
    if (sh > SH_W'(Y_MAX)) begin
      y_sat = Y_MAX;
    end else if (sh < SH_W'(Y_MIN)) begin
      y_sat = Y_MIN;
    end else begin
      y_sat = sh[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    sum = SUM_W'(energy_r) + SUM_W'(prod[SQ_W-1:0]);
    if (sum >= SUM_W'(E_MAX)) begin
      energy_nxt = E_MAX;
      esat_nxt   = 1'b1;
    end else begin
      energy_nxt = sum[ENERGY_BITS-1:0];
      esat_nxt   = esat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bqe_pkg::NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_valid && (cfg_addr < bqe_pkg::CFG_ADDR_BITS'(bqe_pkg::NUM_COEF))) begin
      coef_r[cfg_addr] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r     <= '0;
      x2_r     <= '0;
      y1_r     <= '0;
      y2_r     <= '0;
      energy_r <= '0;
      esat_r   <= 1'b0;
    end else begin
      if (in_fire && in_tuser) begin
        x1_r     <= '0;
        x2_r     <= '0;
        y1_r     <= '0;
        y2_r     <= '0;
        energy_r <= '0;
        esat_r   <= 1'b0;
      end else if (ctl.y_load) begin
        x1_r <= x_r;
        x2_r <= x1_r;
        y1_r <= y_sat;
        y2_r <= y1_r;
      end else if (ctl.out_load) begin
        energy_r <= energy_nxt;
        esat_r   <= esat_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r <= in_tdata[SAMPLE_BITS-1:0];
    end
    if (ctl.y_load) begin
      y_r <= y_sat;
    end
    if (ctl.out_load) begin
      out_data_r <= OUT_TW'({energy_nxt, y_r});
      out_user_r <= esat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input accepted again while a sample is in flight");

  a_sat_means_max: assert property (@(posedge clk) disable iff (!rst_n)
    esat_r |-> (energy_r == E_MAX))
    else $error("saturation flag set with energy below maximum");

  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (esat_r && !(in_fire && in_tuser)) |=> esat_r)
    else $error("saturation flag dropped without a record start");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while still pending");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the biquad band-pass energy block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W = 16;
  localparam int ENERGY_W = 48;
  localparam int IN_W     = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_W    = ((SAMPLE_W + ENERGY_W + 7) / 8) * 8;

  localparam int CMAX = (1 << (bqe_pkg::COEF_BITS - 1)) - 1;
  localparam int CMIN = -CMAX - 1;
  localparam longint SMAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam longint unsigned EMAX = (longint'(1) << ENERGY_W) - 1;
  localparam real PI = 3.14159265358979323846;

  localparam int NUM_BLOCKS  = 6;
  localparam int BLOCK_ITEMS = 275;

  typedef int coef_set_t [bqe_pkg::NUM_COEF];

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic [ENERGY_W-1:0]        energy;
    logic                       sat;
  } filt_result_t;

  class filter_scoreboard;
    logic signed [bqe_pkg::COEF_BITS-1:0] coef [bqe_pkg::NUM_COEF];
    logic signed [SAMPLE_W-1:0]  x1, x2, y1, y2;
    logic [ENERGY_W-1:0]         energy;
    logic                        sat;
    filt_result_t                expected_outputs [$];
    int                          errors;

    function new();
      foreach (coef[k]) coef[k] = '0;
      clear_record();
      errors = 0;
    endfunction

    function void clear_record();
      x1 = '0;
      x2 = '0;
      y1 = '0;
      y2 = '0;
      energy = '0;
      sat = 1'b0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t ns: %s", $time, msg);
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    function void set_coef(bqe_pkg::reg_idx_t idx, logic [bqe_pkg::COEF_BITS-1:0] v);
      if (idx < bqe_pkg::NUM_COEF) coef[idx] = v;
    endfunction

    // Filter one accepted sample and queue the expected output beat.
    function void note_sample(logic [SAMPLE_W-1:0] raw, logic start);
      logic signed [SAMPLE_W-1:0] x;
      longint acc, y;
      longint unsigned sum;
      filt_result_t res;
      x = raw;
      if (start) clear_record();
      acc = longint'(coef[bqe_pkg::REG_B0]) * longint'(x)
          + longint'(coef[bqe_pkg::REG_B1]) * longint'(x1)
          + longint'(coef[bqe_pkg::REG_B2]) * longint'(x2)
          - longint'(coef[bqe_pkg::REG_A1]) * longint'(y1)
          - longint'(coef[bqe_pkg::REG_A2]) * longint'(y2);
      // arithmetic shift floors, so a tie goes toward plus infinity
      y = (acc + (longint'(1) << (bqe_pkg::FRAC_BITS - 1))) >>> bqe_pkg::FRAC_BITS;
      if (y > SMAX) y = SMAX;
      if (y < SMIN) y = SMIN;
      x2 = x1;
      x1 = x;
      y2 = y1;
      y1 = SAMPLE_W'(y);
      sum = longint'(energy) + longint'(y * y);
      if (sum >= EMAX) begin
        sum = EMAX;
        sat = 1'b1;
      end
      energy = ENERGY_W'(sum);
      res.sample = y1;
      res.energy = energy;
      res.sat = sat;
      expected_outputs.push_back(res);
    endfunction

    function void check_result(logic [OUT_W-1:0] tdata, logic tuser);
      filt_result_t exp_r;
      logic signed [SAMPLE_W-1:0] got_s;
      logic [ENERGY_W-1:0] got_e;
      got_s = tdata[SAMPLE_W-1:0];
      got_e = tdata[SAMPLE_W +: ENERGY_W];
      if (expected_outputs.size() == 0) begin
        flag($sformatf("output beat with nothing expected: sample %0d energy %0d sat %0b",
                       got_s, got_e, tuser));
        return;
      end
      exp_r = expected_outputs.pop_front();
      if (got_s !== exp_r.sample)
        flag($sformatf("filtered sample: expected %0d, got %0d", exp_r.sample, got_s));
      if (got_e !== exp_r.energy)
        flag($sformatf("energy total: expected %0d, got %0d", exp_r.energy, got_e));
      if (tuser !== exp_r.sat)
        flag($sformatf("energy saturated: expected %0b, got %0b", exp_r.sat, tuser));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;   // sample_in
  logic             in_tuser = 1'b0; // start_record

  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;       // filtered_sample, energy_total
  logic             out_tuser;       // energy_saturated

  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  bqe_pkg::reg_idx_t             cfg_addr = '0;
  logic [bqe_pkg::COEF_BITS-1:0] cfg_data = '0;

  int send_idle_pct = 28;
  int recv_idle_pct = 62;

  filter_scoreboard sb;

  biquad_bandpass_energy #(
    .SAMPLE_BITS(SAMPLE_W),
    .ENERGY_BITS(ENERGY_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Output check runs before the input is noted, so queue order stays intact.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready) sb.note_sample(in_tdata[SAMPLE_W-1:0], in_tuser);
      if (cfg_valid && cfg_ready) sb.set_coef(cfg_addr, cfg_data);
    end
  end

  task automatic send_sample(input int s, input logic st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_W'(SAMPLE_W'(s));
    in_tuser <= st;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and let every outstanding output beat come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input bqe_pkg::reg_idx_t idx, input int v);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= bqe_pkg::COEF_BITS'(v);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_coefs(input coef_set_t c, input bit stray);
    bqe_pkg::reg_idx_t regs [bqe_pkg::NUM_COEF];
    regs = '{bqe_pkg::REG_B0, bqe_pkg::REG_B1, bqe_pkg::REG_B2,
             bqe_pkg::REG_A1, bqe_pkg::REG_A2};
    for (int k = 0; k < bqe_pkg::NUM_COEF; k++) write_reg(regs[k], c[k]);
    // indexes past the coefficient file must be dropped
    if (stray)
      for (int k = bqe_pkg::NUM_COEF; k < (1 << bqe_pkg::CFG_ADDR_BITS); k++)
        write_reg(bqe_pkg::reg_idx_t'(k), int'($urandom_range(2 * CMAX + 1)) + CMIN);
    cfg_valid <= 1'b0;
  endtask

  function automatic coef_set_t bandpass_coefs(input real f0, input real q, input real fs);
    coef_set_t c;
    real w0, alpha, a0;
    w0 = 2.0 * PI * f0 / fs;
    alpha = $sin(w0) / (2.0 * q);
    a0 = 1.0 + alpha;
    c[bqe_pkg::REG_B0] = int'(alpha / a0 * 32768.0);
    c[bqe_pkg::REG_B1] = 0;
    c[bqe_pkg::REG_B2] = -c[bqe_pkg::REG_B0];
    c[bqe_pkg::REG_A1] = int'(-2.0 * $cos(w0) / a0 * 32768.0);
    c[bqe_pkg::REG_A2] = int'((1.0 - alpha) / a0 * 32768.0);
    return c;
  endfunction

  function automatic coef_set_t random_coefs();
    coef_set_t c;
    real f0, q;
    case ($urandom_range(3))
      0: begin
        f0 = 20.0 + $urandom_range(23000);
        q = 0.3 + $urandom_range(2000) / 100.0;
        c = bandpass_coefs(f0, q, 48000.0);
      end
      1: foreach (c[k]) c[k] = ($urandom_range(1) != 0) ? CMAX : CMIN;
      2: foreach (c[k]) c[k] = int'($urandom_range(8000)) - 4000;
      default: foreach (c[k]) c[k] = int'($urandom_range(2 * CMAX + 1)) + CMIN;
    endcase
    return c;
  endfunction

  function automatic int random_sample();
    case ($urandom_range(9))
      0: return ($urandom_range(1) != 0) ? int'(SMAX) : int'(SMIN);
      1: return int'($urandom_range(15)) - 8;
      default: return int'($urandom_range(65535)) + int'(SMIN);
    endcase
  endfunction

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // coefficients are zero out of reset: silence, no energy
    send_sample(int'(SMAX), 1'b0);
    send_sample(int'(SMIN), 1'b1);
    drain();

    // b0 = one LSB: the product is the sample, so halves land on ties
    load_coefs('{1, 0, 0, 0, 0}, 1'b0);
    send_sample(16384, 1'b1);
    send_sample(-16384, 1'b0);
    send_sample(-16385, 1'b0);
    send_sample(16383, 1'b0);
    send_sample(-1, 1'b0);
    drain();

    load_coefs('{CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1);
    send_sample(int'(SMAX), 1'b1);
    send_sample(int'(SMAX), 1'b0);
    send_sample(int'(SMIN), 1'b0);
    send_sample(0, 1'b0);
    drain();

    load_coefs('{CMIN, CMIN, CMIN, CMIN, CMIN}, 1'b0);
    send_sample(int'(SMIN), 1'b1);
    send_sample(int'(SMAX), 1'b0);
    send_sample(1, 1'b0);
    drain();

    load_coefs(bandpass_coefs(1000.0, 2.0, 48000.0), 1'b0);
    send_sample(1, 1'b1);
    send_sample(int'(SMAX), 1'b0);
    send_sample(int'(SMIN), 1'b0);
    send_sample(12000, 1'b0);
    send_sample(-5000, 1'b1);
    send_sample(0, 1'b0);
    drain();

    for (int b = 0; b < NUM_BLOCKS; b++) begin
      int pause_at;
      case (b / 2)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      load_coefs(random_coefs(), $urandom_range(3) == 0);
      pause_at = $urandom_range(BLOCK_ITEMS - 1);
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        if (i == pause_at) drain();
        send_sample(random_sample(), (i == 0) || ($urandom_range(39) == 0));
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
